>>> rtl/core/mscr_pkg.sv
// Package: widths, codes, item types and controller/datapath interface types.
package mscr_pkg;

  localparam int TIME_BITS  = 32;
  localparam int WIDTH_BITS = 16;

  localparam int TW_W      = 16;
  localparam int NOW_W     = 32;
  localparam int OFS_W     = 20;
  localparam int SPD_W     = 10;
  localparam int ESPD_W    = 16;
  localparam int AV_W      = 14;
  localparam int DIFF_W    = 18;
  localparam int WIN_W     = 12;
  localparam int PAD_W     = 8;
  localparam int THR_W     = 8;
  localparam int MS_W      = 16;
  localparam int DEN_W     = 20;
  localparam int CMP_W     = 22;
  localparam int NUM_W     = SPD_W + TW_W;
  localparam int DIV_Q     = 20;
  localparam int DIVD_W    = (TIME_BITS + ESPD_W > NUM_W + 8) ? TIME_BITS + ESPD_W : NUM_W + 8;
  localparam int LIMK_W    = OFS_W + 10;
  localparam int CNT_W     = $clog2(DIV_Q + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // ceil(2^38 / 1000): exact floor division by 1000 for dividends below 2^LIMK_W
  localparam int RCP_W  = 29;
  localparam int RCP_SH = 38;
  localparam int RCP_PW = LIMK_W + RCP_W;

  localparam logic [63:0]       WMAX        = (64'd1 << WIDTH_BITS) - 64'd1;
  localparam logic [63:0]       ELAPSED_CAP = 64'd1 << 40;
  localparam logic [OFS_W-1:0]  OFS_MAX     = '1;
  localparam logic [DEN_W-1:0]  MS_PER_SEC  = DEN_W'(1000);
  localparam logic [RCP_W-1:0]  RCP_MS      = RCP_W'(274877907);

  localparam logic [1:0] MODE_BOUNCE = 2'd0;
  localparam logic [1:0] MODE_LOOP   = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_MODE      = 3'd1,
    CFG_SPEED     = 3'd2,
    CFG_DELAY     = 3'd3,
    CFG_PAUSE     = 3'd4,
    CFG_WINDOW    = 3'd5,
    CFG_PADDING   = 3'd6,
    CFG_THRESHOLD = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DELAY   = 3'd1,
    PH_LEFT    = 3'd2,
    PH_PAUSE_R = 3'd3,
    PH_RIGHT   = 3'd4,
    PH_PAUSE_L = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NL_A,
    OP_NL_B,
    OP_TR_A,
    OP_TR_B,
    OP_TR_C,
    OP_DIV_START,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_NL_A,
    CS_NL_B,
    CS_TR_A,
    CS_TR_B,
    CS_TR_C,
    CS_CHECK,
    CS_DIV_START,
    CS_DIV_WAIT,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic off;
    logic req;
    logic scroll_phase;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic             req_type;
    logic [TW_W-1:0]  text_width;
    logic [NOW_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [OFS_W-1:0] scroll_offset;
    logic             need_redraw;
    logic [2:0]       scroll_phase;
  } out_item_t;

endpackage

>>> rtl/core/marquee_scroll_controller_top.sv
// Top level: marquee scroll controller, controller plus datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid / in_ready    | in_data (req_type, text_width, now_ms)
//   out     | output    | out_valid / out_ready  | out_data (scroll_offset, need_redraw,
//           |           |                        |           scroll_phase)
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One item at a time; in_ready is high only between items. An accepted item passes DISPATCH,
// then NL_A, NL_B and CHECK for new lines or TR_A, TR_B, TR_C and CHECK for scrolling frames
// (reciprocal multiply by 1/1000); off, idle, delay and pause items go straight on. New lines
// that need the speedup ratio add DIV_START and DIV_WAIT (20-step serial divider). FINISH
// writes the output register; a finished result holds in the controller while the output
// beat waits; input stalls then. Synchronous reset restores the register defaults and the idle phase.
module marquee_scroll_controller_top import mscr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mscr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mscr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/mscr_div.sv
// Iterative restoring divider: one quotient bit per cycle, quotient below 2^DIV_Q.
module mscr_div import mscr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_Q-1:0]  quot
);

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DIV_Q-1:0]  qr;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W-1:0]  rem_next;

  assign trial    = {rem, qr[DIV_Q-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign rem_next = fits ? DEN_W'(trial - {1'b0, dsr}) : DEN_W'(trial);
  assign quot     = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_Q);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits stay below the divisor, so they seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(dividend >> DIV_Q);
      qr  <= dividend[DIV_Q-1:0];
      dsr <= divisor;
    end else if (running) begin
      rem <= rem_next;
      qr  <= {qr[DIV_Q-2:0], fits};
    end
  end

endmodule

>>> rtl/core/mscr_dp.sv
// Datapath: configuration registers, scroll state, arithmetic and result register.
module mscr_dp import mscr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_item_t            out_data
);

  // configuration
  logic              en;
  logic [1:0]        mode;
  logic [SPD_W-1:0]  spd;
  logic [MS_W-1:0]   delay_ms;
  logic [MS_W-1:0]   pause_ms;
  logic [WIN_W-1:0]  win;
  logic [PAD_W-1:0]  pad;
  logic [THR_W-1:0]  thr;

  // item
  logic                 req_r;
  logic [TW_W-1:0]      w_r;
  logic [TIME_BITS-1:0] now_r;

  // scroll state
  phase_t                phase;
  logic [TIME_BITS-1:0]  phase_start;
  logic [WIDTH_BITS-1:0] max_offset;
  logic [OFS_W-1:0]      cur;
  logic [ESPD_W-1:0]     eff;

  // scratch
  logic signed [AV_W-1:0] avail_r;
  logic [DEN_W-1:0]       den_r;
  logic [TIME_BITS-1:0]   elapsed_r;
  logic [LIMK_W-1:0]      limk_r;
  logic [DIVD_W-1:0]      prod_r;
  logic                   f_cap;
  logic                   f_div;
  logic                   need_div;
  logic [OFS_W-1:0]       d_r;

  logic             div_done;
  logic [DIV_Q-1:0] div_q;
  logic [DEN_W-1:0] div_dsr;

  logic signed [AV_W-1:0]  avail_c;
  logic                    avail_pos_c;
  logic                    avail_pos_r;
  logic [WIDTH_BITS+3:0]   lim_full;
  logic [OFS_W-1:0]        limit;
  logic [CMP_W-1:0]        w16;
  logic [CMP_W-1:0]        den3;
  logic                    gt;
  logic                    ge3;
  logic                    big;
  logic                    sat;
  logic [TIME_BITS-1:0]    elapsed_c;
  logic [OFS_W-1:0]        d_c;
  logic [RCP_PW-1:0]       rcp_prod;
  logic [OFS_W-1:0]        rcp_q;

  // finish values
  logic signed [DIFF_W-1:0] ws;
  logic signed [DIFF_W-1:0] as;
  logic [DIFF_W-1:0]        diff_u;
  logic                     line_scrolls;
  logic [ESPD_W-1:0]        spd16;
  logic [ESPD_W-1:0]        spd48;
  logic                     off_c;
  logic                     bounce;
  phase_t                   ph_next;
  logic [TIME_BITS-1:0]     ps_next;
  logic [WIDTH_BITS-1:0]    mo_next;
  logic [OFS_W-1:0]         cur_next;
  logic [ESPD_W-1:0]        eff_next;
  logic                     redraw;

  assign avail_c     = $signed({2'b00, win}) - $signed({5'b00000, pad, 1'b0});
  assign avail_pos_c = !avail_c[AV_W-1] && (avail_c != '0);
  assign avail_pos_r = !avail_r[AV_W-1] && (avail_r != '0);

  assign lim_full = {max_offset, 4'b0000};
  assign limit    = (64'(lim_full) > 64'(OFS_MAX)) ? OFS_MAX : OFS_W'(lim_full);

  assign w16  = CMP_W'({w_r, 4'b0000});
  assign den3 = CMP_W'({den_r, 1'b0}) + CMP_W'(den_r);
  assign gt   = w16 > CMP_W'(den_r);
  assign ge3  = w16 >= den3;

  assign big = (TIME_BITS > 40) && (64'(elapsed_r) > ELAPSED_CAP) && (eff != '0);
  assign sat = big || (prod_r >= DIVD_W'(limk_r));

  // short of the end of travel the product stays below limit * 1000, so 30 bits
  assign rcp_prod = RCP_PW'(prod_r[LIMK_W-1:0]) * RCP_PW'(RCP_MS);
  assign rcp_q    = rcp_prod[RCP_SH+OFS_W-1:RCP_SH];

  assign elapsed_c = now_r - phase_start;
  assign d_c       = need_div ? OFS_W'(div_q) : d_r;

  assign off_c  = !en || (mode == MODE_OFF);
  assign bounce = mode != MODE_LOOP;

  assign div_dsr = den_r;

  assign status.off          = off_c;
  assign status.req          = req_r;
  assign status.scroll_phase = (phase == PH_LEFT) || (phase == PH_RIGHT);
  assign status.need_div     = need_div;
  assign status.div_done     = div_done;
  assign status.out_free     = !out_valid || out_ready;

  mscr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_START),
    .dividend (prod_r),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      en       <= 1'b1;
      mode     <= MODE_BOUNCE;
      spd      <= SPD_W'(30);
      delay_ms <= MS_W'(1000);
      pause_ms <= MS_W'(1000);
      win      <= WIN_W'(400);
      pad      <= PAD_W'(10);
      thr      <= THR_W'(24);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    en       <= cfg_data[0];
        CFG_MODE:      mode     <= cfg_data[1:0];
        CFG_SPEED:     spd      <= cfg_data[SPD_W-1:0];
        CFG_DELAY:     delay_ms <= cfg_data[MS_W-1:0];
        CFG_PAUSE:     pause_ms <= cfg_data[MS_W-1:0];
        CFG_WINDOW:    win      <= cfg_data[WIN_W-1:0];
        CFG_PADDING:   pad      <= cfg_data[PAD_W-1:0];
        CFG_THRESHOLD: thr      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // work registers, sequenced by the controller
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r <= in_data.req_type;
        w_r   <= in_data.text_width;
        now_r <= TIME_BITS'(in_data.now_ms);
      end
      OP_NL_A: begin
        avail_r <= avail_c;
        den_r   <= avail_pos_c ? DEN_W'(avail_c[WIN_W-1:0]) * DEN_W'(thr) : '0;
      end
      OP_NL_B: begin
        f_cap    <= !avail_pos_r || (gt && ge3);
        f_div    <= avail_pos_r && gt && !ge3;
        need_div <= avail_pos_r && gt && !ge3;
        prod_r   <= DIVD_W'({NUM_W'(spd) * NUM_W'(w_r), 8'h00});
      end
      OP_TR_A: begin
        elapsed_r <= elapsed_c;
        limk_r    <= LIMK_W'(limit) * LIMK_W'(MS_PER_SEC);
      end
      OP_TR_B: begin
        prod_r <= DIVD_W'(elapsed_r) * DIVD_W'(eff);
      end
      OP_TR_C: begin
        d_r      <= sat ? limit : rcp_q;
        need_div <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ws           = $signed({2'b00, w_r});
    as           = DIFF_W'(avail_r);
    diff_u       = DIFF_W'(ws - as);
    line_scrolls = ws > (as + DIFF_W'(1));
    spd16        = ESPD_W'({spd, 4'b0000});
    spd48        = ESPD_W'({spd, 5'b00000}) + ESPD_W'({spd, 4'b0000});

    ph_next  = phase;
    ps_next  = phase_start;
    mo_next  = max_offset;
    cur_next = cur;
    eff_next = eff;
    redraw   = 1'b0;

    if (off_c) begin
      if (phase != PH_IDLE) begin
        ph_next  = PH_IDLE;
        cur_next = '0;
        redraw   = 1'b1;
      end
    end else if (req_r) begin
      cur_next = '0;
      ps_next  = now_r;
      redraw   = 1'b1;
      if (line_scrolls) begin
        mo_next = (64'(diff_u) > WMAX) ? WIDTH_BITS'(WMAX) : WIDTH_BITS'(diff_u);
        ph_next = PH_DELAY;
      end else begin
        mo_next = '0;
        ph_next = PH_IDLE;
      end
      if (f_cap) begin
        eff_next = spd48;
      end else if (f_div) begin
        eff_next = ESPD_W'(div_q);
      end else begin
        eff_next = spd16;
      end
    end else begin
      case (phase)
        PH_DELAY: begin
          if (elapsed_c >= TIME_BITS'(delay_ms)) begin
            ph_next  = PH_LEFT;
            ps_next  = now_r;
            cur_next = '0;
          end
        end
        PH_LEFT: begin
          cur_next = d_c;
          redraw   = 1'b1;
          if (d_c >= limit) begin
            ps_next = now_r;
            if (bounce) begin
              ph_next  = PH_PAUSE_R;
              cur_next = limit;
            end else begin
              ph_next  = PH_DELAY;
              cur_next = '0;
            end
          end
        end
        PH_PAUSE_R: begin
          cur_next = limit;
          if (elapsed_c >= TIME_BITS'(pause_ms)) begin
            ph_next = PH_RIGHT;
            ps_next = now_r;
          end
        end
        PH_RIGHT: begin
          cur_next = limit - d_c;
          redraw   = 1'b1;
          if (limit == d_c) begin
            ph_next = PH_PAUSE_L;
            ps_next = now_r;
          end
        end
        PH_PAUSE_L: begin
          if (elapsed_c >= TIME_BITS'(pause_ms)) begin
            ph_next = PH_DELAY;
            ps_next = now_r;
          end
        end
        PH_IDLE: ;
        default: begin
          ph_next  = PH_IDLE;
          cur_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_start <= '0;
      max_offset  <= '0;
      cur         <= '0;
      eff         <= '0;
    end else if (cmd.op == OP_FINISH) begin
      phase       <= ph_next;
      phase_start <= ps_next;
      max_offset  <= mo_next;
      cur         <= cur_next;
      eff         <= eff_next;
    end
  end

  // result beat holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_data.scroll_offset <= cur_next;
      out_data.need_redraw   <= redraw;
      out_data.scroll_phase  <= ph_next;
    end
  end

endmodule

>>> rtl/core/mscr_ctrl.sv
// Controller: sequences one item through the datapath and hands off the result.
module mscr_ctrl import mscr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        if (status.off) begin
          state_next = CS_FINISH;
        end else if (status.req) begin
          state_next = CS_NL_A;
        end else if (status.scroll_phase) begin
          state_next = CS_TR_A;
        end else begin
          state_next = CS_FINISH;
        end
      end
      CS_NL_A: begin
        cmd.op     = OP_NL_A;
        state_next = CS_NL_B;
      end
      CS_NL_B: begin
        cmd.op     = OP_NL_B;
        state_next = CS_CHECK;
      end
      CS_TR_A: begin
        cmd.op     = OP_TR_A;
        state_next = CS_TR_B;
      end
      CS_TR_B: begin
        cmd.op     = OP_TR_B;
        state_next = CS_TR_C;
      end
      CS_TR_C: begin
        cmd.op     = OP_TR_C;
        state_next = CS_CHECK;
      end
      CS_CHECK: begin
        state_next = status.need_div ? CS_DIV_START : CS_FINISH;
      end
      CS_DIV_START: begin
        cmd.op     = OP_DIV_START;
        state_next = CS_DIV_WAIT;
      end
      CS_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = CS_FINISH;
        end
      end
      CS_FINISH: begin
        // hold while the previous result beat is still waiting
        if (status.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

>>> tb/sv/tb_marquee_scroll_controller_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the marquee scroll controller: directed phase walks plus random traffic.
module tb_marquee_scroll_controller_top;
  import mscr_pkg::*;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_LINE  = 1'b1;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // register copies, reset values
  logic        cfg_en     = 1'b1;
  logic [1:0]  cfg_mode   = MODE_BOUNCE;
  logic [9:0]  cfg_speed  = 10'd30;
  logic [15:0] cfg_delay  = 16'd1000;
  logic [15:0] cfg_pause  = 16'd1000;
  logic [11:0] cfg_window = 12'd400;
  logic [7:0]  cfg_pad    = 8'd10;
  logic [7:0]  cfg_thr    = 8'd24;

  // scroll state
  phase_t      sc_phase = PH_IDLE;
  logic [31:0] sc_start = '0;
  logic [15:0] sc_width = '0;
  logic [15:0] sc_max   = '0;
  logic [19:0] sc_ofs   = '0;
  logic [15:0] sc_speed = '0;

  out_item_t results_due[$];
  int        err_count    = 0;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        cfg_phases   = 0;
  int        idle_pct     = 15;
  bit        hold_request = 1'b0;

  marquee_scroll_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // 1/16 px covered after elapsed ms, clipped to the end of travel
  function automatic logic [19:0] distance_moved(logic [31:0] elapsed, logic [19:0] lim);
    longint unsigned d;
    if (sc_speed == 0) return '0;
    d = longint'(elapsed) * longint'(sc_speed) / 1000;
    return (d < longint'(lim)) ? d[19:0] : lim;
  endfunction

  function automatic void begin_line(logic [15:0] w, logic [31:0] now);
    longint avail;
    longint wl;
    longint spd;
    longint den;
    longint over;
    longint eff;
    avail = longint'(cfg_window) - 2 * longint'(cfg_pad);
    wl    = longint'(w);
    spd   = longint'(cfg_speed);
    sc_width = w;
    sc_ofs   = '0;
    if (wl > avail + 1) begin
      over     = wl - avail;
      sc_max   = (over > 65535) ? 16'hFFFF : over[15:0];
      sc_phase = PH_DELAY;
    end else begin
      sc_max   = '0;
      sc_phase = PH_IDLE;
    end
    eff = spd * 16;
    if (avail <= 0) begin
      eff = spd * 48;
    end else begin
      den = avail * longint'(cfg_thr);
      if (16 * wl > den) begin
        // speedup ratio, capped at 3x
        eff = (16 * wl >= 3 * den) ? spd * 48 : (spd * 256 * wl) / den;
      end
    end
    sc_speed = eff[15:0];
    sc_start = now;
  endfunction

  function automatic out_item_t scroll_step(in_item_t it);
    out_item_t   r;
    logic [31:0] elapsed;
    logic [19:0] lim;
    logic        redraw;
    logic        bounce;
    elapsed = it.now_ms - sc_start;
    lim     = {sc_max, 4'b0000};
    redraw  = 1'b0;
    bounce  = (cfg_mode != MODE_LOOP);
    if (!cfg_en || cfg_mode == MODE_OFF) begin
      if (sc_phase != PH_IDLE) begin
        sc_phase = PH_IDLE;
        sc_ofs   = '0;
        redraw   = 1'b1;
      end
    end else if (it.req_type == REQ_LINE) begin
      begin_line(it.text_width, it.now_ms);
      redraw = 1'b1;
    end else begin
      case (sc_phase)
        PH_DELAY: begin
          if (elapsed >= 32'(cfg_delay)) begin
            sc_phase = PH_LEFT;
            sc_start = it.now_ms;
            sc_ofs   = '0;
          end
        end
        PH_LEFT: begin
          sc_ofs = distance_moved(elapsed, lim);
          redraw = 1'b1;
          if (sc_ofs >= lim) begin
            sc_start = it.now_ms;
            if (bounce) begin
              sc_phase = PH_PAUSE_R;
            end else begin
              sc_phase = PH_DELAY;
              sc_ofs   = '0;
            end
          end
        end
        PH_PAUSE_R: begin
          sc_ofs = lim;
          if (elapsed >= 32'(cfg_pause)) begin
            sc_phase = PH_RIGHT;
            sc_start = it.now_ms;
          end
        end
        PH_RIGHT: begin
          sc_ofs = lim - distance_moved(elapsed, lim);
          redraw = 1'b1;
          if (sc_ofs == 0) begin
            sc_phase = PH_PAUSE_L;
            sc_start = it.now_ms;
          end
        end
        PH_PAUSE_L: begin
          if (elapsed >= 32'(cfg_pause)) begin
            sc_phase = PH_DELAY;
            sc_start = it.now_ms;
          end
        end
        default: ;
      endcase
    end
    r.scroll_offset = sc_ofs;
    r.need_redraw   = redraw;
    r.scroll_phase  = sc_phase;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint exp_val, longint got_val);
    $display("MISMATCH at %0t, result %0d: %s expected %0d got %0d",
             $realtime, results_seen, what, exp_val, got_val);
    err_count++;
  endtask

  task automatic send_item(logic req, logic [15:0] w, logic [31:0] now);
    in_item_t it;
    it.req_type   = req;
    it.text_width = w;
    it.now_ms     = now;
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(scroll_step(it));
    items_sent++;
  endtask

  // drop valid and let every outstanding result drain
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need a single assignment per edge
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val, logic [15:0] keep);
    logic [15:0] data;
    data = ($urandom_range(0, 1) != 0) ? (val | (16'($urandom) & ~keep)) : val;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE:    cfg_en     = data[0];
      CFG_MODE:      cfg_mode   = data[1:0];
      CFG_SPEED:     cfg_speed  = data[9:0];
      CFG_DELAY:     cfg_delay  = data;
      CFG_PAUSE:     cfg_pause  = data;
      CFG_WINDOW:    cfg_window = data[11:0];
      CFG_PADDING:   cfg_pad    = data[7:0];
      CFG_THRESHOLD: cfg_thr    = data[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic en, logic [1:0] mode, logic [9:0] spd, logic [15:0] dly,
                           logic [15:0] pause, logic [11:0] win, logic [7:0] pad,
                           logic [7:0] thr);
    quiesce();
    write_reg(CFG_ENABLE, 16'(en), 16'h0001);
    write_reg(CFG_MODE, 16'(mode), 16'h0003);
    write_reg(CFG_SPEED, 16'(spd), 16'h03FF);
    write_reg(CFG_DELAY, dly, 16'hFFFF);
    write_reg(CFG_PAUSE, pause, 16'hFFFF);
    write_reg(CFG_WINDOW, 16'(win), 16'h0FFF);
    write_reg(CFG_PADDING, 16'(pad), 16'h00FF);
    write_reg(CFG_THRESHOLD, 16'(thr), 16'h00FF);
    cfg_valid <= 1'b0;
    cfg_phases++;
  endtask

  // Reset settings, 500 px line: delay, left, pause right, right, pause left, delay.
  task automatic test_default_walk();
    int unsigned walk_t [8];
    walk_t = '{1500, 2000, 4000, 6000, 7000, 9000, 11000, 12000};
    send_item(REQ_FRAME, 16'($urandom), 32'd0);
    send_item(REQ_LINE, 16'd500, 32'd1000);
    foreach (walk_t[i]) send_item(REQ_FRAME, 16'($urandom), walk_t[i]);
  endtask

  // Loop mode, negative usable width, widest line, time wrap and saturation at loop end.
  task automatic test_loop_wrap_saturation();
    configure(1'b1, MODE_LOOP, 10'd1023, 16'd0, 16'd0, 12'd1, 8'd255, 8'd0);
    send_item(REQ_LINE, 16'hFFFF, 32'hFFFF_FF00);
    send_item(REQ_FRAME, 16'($urandom), 32'hFFFF_FF00);
    send_item(REQ_FRAME, 16'($urandom), 32'h0000_0100);
    send_item(REQ_FRAME, 16'($urandom), 32'h7FFF_0000);
    send_item(REQ_FRAME, 16'($urandom), 32'h7FFF_0000);
  endtask

  // Zero threshold forces the 3x cap; the undefined mode code decodes as bounce.
  task automatic test_threshold_cap_mode3();
    configure(1'b1, MODE_LOOP | MODE_OFF, 10'd100, 16'hFFFF, 16'hFFFF, 12'd4095, 8'd0,
              8'd0);
    send_item(REQ_LINE, 16'd5000, 32'd0);
    send_item(REQ_FRAME, 16'($urandom), 32'd65534);
    send_item(REQ_FRAME, 16'($urandom), 32'd65535);
    send_item(REQ_FRAME, 16'($urandom), 32'd67535);
    send_item(REQ_FRAME, 16'($urandom), 32'd165535);
  endtask

  // Zero speed never moves; width exactly at the scroll boundary stays idle.
  task automatic test_speed_zero_boundary();
    logic [31:0] t0;
    t0 = $urandom;
    configure(1'b1, MODE_BOUNCE, 10'd0, 16'd0, 16'd0, 12'd200, 8'd0, 8'd255);
    send_item(REQ_LINE, 16'd201, t0);
    send_item(REQ_LINE, 16'd202, t0 + 1);
    send_item(REQ_FRAME, 16'($urandom), t0 + 2);
    send_item(REQ_FRAME, 16'($urandom), t0 + 1000000);
    send_item(REQ_LINE, 16'd0, t0 + 1000001);
  endtask

  // Off mode and master disable both force idle and clear the offset.
  task automatic test_forced_idle();
    configure(1'b1, MODE_BOUNCE, 10'd30, 16'd1000, 16'd1000, 12'd400, 8'd10, 8'd24);
    send_item(REQ_LINE, 16'd600, 32'd0);
    configure(1'b1, MODE_OFF, 10'd30, 16'd1000, 16'd1000, 12'd400, 8'd10, 8'd24);
    send_item(REQ_LINE, 16'd600, 32'd100);
    send_item(REQ_FRAME, 16'($urandom), 32'd200);
    configure(1'b1, MODE_BOUNCE, 10'd30, 16'd1000, 16'd1000, 12'd400, 8'd10, 8'd24);
    send_item(REQ_LINE, 16'd600, 32'd0);
    send_item(REQ_FRAME, 16'($urandom), 32'd1000);
    send_item(REQ_FRAME, 16'($urandom), 32'd3000);
    configure(1'b0, MODE_BOUNCE, 10'd30, 16'd1000, 16'd1000, 12'd400, 8'd10, 8'd24);
    send_item(REQ_FRAME, 16'($urandom), 32'd3500);
    send_item(REQ_LINE, 16'd600, 32'd4000);
  endtask

  // Receiver holds off while frames keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    configure(1'b1, MODE_BOUNCE, 10'd30, 16'd500, 16'd500, 12'd400, 8'd10, 8'd24);
    idle_pct     = 0;
    hold_request = 1'b1;
    send_item(REQ_LINE, 16'd700, 32'd0);
    for (int i = 1; i <= 14; i++) send_item(REQ_FRAME, 16'($urandom), 32'(i * 700));
    idle_pct = 15;
  endtask

  // Pick the next frame time so each phase is left after a few frames.
  function automatic logic [31:0] next_frame_time(logic [31:0] last);
    longint span;
    int     r;
    case (sc_phase)
      PH_DELAY:               span = cfg_delay;
      PH_PAUSE_R, PH_PAUSE_L: span = cfg_pause;
      PH_LEFT, PH_RIGHT: begin
        span = (sc_speed == 0) ? 2000 :
               (longint'({sc_max, 4'b0000}) * 1000 + sc_speed - 1) / sc_speed;
      end
      default:                span = 1000;
    endcase
    r = $urandom_range(1, 100);
    if (r <= 15) return sc_start + 32'(span) - 32'd1 + 32'($urandom_range(0, 2));
    if (r <= 22) return $urandom;
    return last + 32'($urandom_range(0, 32'(span * 3 / 5 + 1)));
  endfunction

  task automatic test_random_traffic();
    int          first_item;
    int          lines;
    int          avail;
    int          wi;
    logic [31:0] t_now;
    logic [15:0] w;
    logic        en;
    logic [1:0]  mode;
    logic [9:0]  spd;
    logic [15:0] dly;
    logic [15:0] pause;
    logic [11:0] win;
    logic [7:0]  pad;
    logic [7:0]  thr;
    first_item = items_sent;
    lines      = 0;
    while (items_sent - first_item < 400) begin
      if (lines % 3 == 0) begin
        en = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: mode = MODE_BOUNCE;
          5, 6, 7:       mode = MODE_LOOP;
          8:             mode = MODE_OFF;
          default:       mode = MODE_LOOP | MODE_OFF;
        endcase
        case ($urandom_range(0, 9))
          0:       spd = 10'd0;
          1:       spd = 10'd1023;
          default: spd = 10'($urandom_range(1, 400));
        endcase
        case ($urandom_range(0, 9))
          0:       dly = 16'd0;
          1:       dly = 16'hFFFF;
          default: dly = 16'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 9))
          0:       pause = 16'd0;
          1:       pause = 16'hFFFF;
          default: pause = 16'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 9))
          0:       win = 12'd1;
          1:       win = 12'd4095;
          default: win = 12'($urandom_range(50, 1000));
        endcase
        case ($urandom_range(0, 9))
          0:       pad = 8'd0;
          1:       pad = 8'd255;
          default: pad = 8'($urandom_range(0, 80));
        endcase
        case ($urandom_range(0, 9))
          0:       thr = 8'd16;
          1:       thr = 8'd255;
          default: thr = 8'($urandom_range(16, 80));
        endcase
        configure(en, mode, spd, dly, pause, win, pad, thr);
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
      end
      // no idling in the last stretch
      if (items_sent - first_item >= 320) idle_pct = 0;
      avail = int'(cfg_window) - 2 * int'(cfg_pad);
      if ($urandom_range(1, 100) <= 15) begin
        w = 16'($urandom);
      end else begin
        wi = avail + int'($urandom_range(0, 500)) - 60;
        w  = (wi < 0) ? 16'd0 : 16'(wi);
      end
      t_now = $urandom;
      send_item(REQ_LINE, w, t_now);
      lines++;
      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(1, 100) <= 6) begin
          // a new line that breaks into the running sequence
          t_now = t_now + 32'($urandom_range(0, 500));
          send_item(REQ_LINE, 16'($urandom), t_now);
        end else begin
          t_now = next_frame_time(t_now);
          send_item(REQ_FRAME, 16'($urandom), t_now);
        end
      end
    end
  endtask

  // compare each output beat against the oldest due result and drive out_ready
  initial begin : result_check
    int        stall;
    out_item_t due;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat, offset", 0, out_data.scroll_offset);
        end else begin
          due = results_due.pop_front();
          if (out_data.scroll_offset !== due.scroll_offset)
            report_mismatch("scroll_offset", due.scroll_offset, out_data.scroll_offset);
          if (out_data.need_redraw !== due.need_redraw)
            report_mismatch("need_redraw", due.need_redraw, out_data.need_redraw);
          if (out_data.scroll_phase !== due.scroll_phase)
            report_mismatch("scroll_phase", due.scroll_phase, out_data.scroll_phase);
        end
        results_seen++;
      end
      if (hold_request) begin
        stall        = 300;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 18) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int spins;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_default_walk();
    test_loop_wrap_saturation();
    test_threshold_cap_mode3();
    test_speed_zero_boundary();
    test_forced_idle();
    test_output_backpressure();
    test_random_traffic();

    idle_pct = 0;
    in_valid <= 1'b0;
    spins = 0;
    while (results_due.size() != 0 && spins < 10000) begin
      @(posedge clk);
      spins++;
    end
    repeat (40) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never delivered", results_due.size(), 0);
    $display("Covered %0d items and %0d results over %0d register settings,",
             items_sent, results_seen, cfg_phases);
    $display("all scroll phases, loop and bounce, off and disabled, long output stall.");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mscr_pkg.sv
rtl/core/mscr_div.sv
rtl/core/mscr_dp.sv
rtl/core/mscr_ctrl.sv
rtl/core/marquee_scroll_controller_top.sv
tb/sv/tb_marquee_scroll_controller_top.sv
